// ----- design/bfi_pkg.sv -----
// Shared types, codes and constants of the breakpoint fractional index block.
package bfi_pkg;

	// Fixed field widths
	localparam int VALUE_W   = 32;
	localparam int SLOT_W    = 5;
	localparam int OUT_W     = 21;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	// Default sizing for the top level
	localparam int DEF_DEPTH     = 32;
	localparam int DEF_FRAC_BITS = 16;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	// Opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASCENDING    = 1'd1;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] TABLE_LENGTH_RST = 6'd32;
	localparam logic             ASCENDING_RST    = 1'b1;

	// One queued command
	typedef struct packed {
		logic               op;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] data;
	} bfi_item_t;

	// Queue status toward the back end
	typedef struct packed {
		logic empty;
		logic full;
	} bfi_q_status_t;

endpackage

// ----- design/breakpoint_fractional_index.sv -----
// Top level of the breakpoint fractional index block.
// Usage: a command is taken at a rising edge with start high and busy low.
// opcode 0 writes breakpoint_value into table slot entry_index and gives no
// result; opcode 1 locates query_value and gives one result. Results appear
// on fractional_index and found for exactly one cycle with done high; the
// receiver cannot stall, so every result must be taken when shown.
// Configuration: cfg_write with cfg_index 0 sets table_length, 1 sets
// ascending; write only while no command is outstanding.
// A query finishes soonest with a clamp at the first entry, then with a clamp
// at the last entry; otherwise its time grows with the segment number found,
// set by the one-entry-per-cycle scan of the single memory read port, and
// includes the one-bit-per-cycle divider. A write is stored as it is popped
// and leaves the back end idle for the next command.
// A two-entry queue parts the front from the back: busy rises only when it is
// full. Reset clears the control state and the registers to length 32,
// ascending; table contents stay undefined until written.
module breakpoint_fractional_index #(
	parameter int DEPTH     = bfi_pkg::DEF_DEPTH,
	parameter int FRAC_BITS = bfi_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bfi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [bfi_pkg::SLOT_W-1:0]    entry_index,
	input  logic [bfi_pkg::VALUE_W-1:0]   breakpoint_value,
	input  logic [bfi_pkg::VALUE_W-1:0]   query_value,
	output logic                          done,
	output logic [bfi_pkg::OUT_W-1:0]     fractional_index,
	output logic                          found
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                   push;
	logic                   pop;
	bfi_pkg::bfi_item_t     push_item;
	bfi_pkg::bfi_item_t     head;
	bfi_pkg::bfi_q_status_t q_status;
	logic [IDX_W-1:0]       last_idx;
	logic                   up;

	bfi_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.entry_index     (entry_index),
		.breakpoint_value(breakpoint_value),
		.query_value     (query_value),
		.q_status        (q_status),
		.push            (push),
		.push_item       (push_item),
		.last_idx        (last_idx),
		.up              (up)
	);

	bfi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	bfi_back #(
		.DEPTH    (DEPTH),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.last_idx        (last_idx),
		.up              (up),
		.done            (done),
		.fractional_index(fractional_index),
		.found           (found)
	);

endmodule

// ----- design/bfi_queue.sv -----
// Two-entry command queue between the front and back ends.
module bfi_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bfi_pkg::bfi_item_t    push_item,
	input  logic                  pop,
	output bfi_pkg::bfi_item_t    head,
	output bfi_pkg::bfi_q_status_t status
);

	bfi_pkg::bfi_item_t               entry_q [bfi_pkg::Q_DEPTH];
	logic [bfi_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [bfi_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [bfi_pkg::Q_PTR_W:0]        count_q;
	logic                             do_push;
	logic                             do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (bfi_pkg::Q_PTR_W+1)'(bfi_pkg::Q_DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// ----- design/bfi_front.sv -----
// Front end: configuration registers, command acceptance and classification.
module bfi_front #(
	parameter int DEPTH = bfi_pkg::DEF_DEPTH,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bfi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [bfi_pkg::SLOT_W-1:0]    entry_index,
	input  logic [bfi_pkg::VALUE_W-1:0]   breakpoint_value,
	input  logic [bfi_pkg::VALUE_W-1:0]   query_value,
	input  bfi_pkg::bfi_q_status_t        q_status,
	output logic                          push,
	output bfi_pkg::bfi_item_t            push_item,
	output logic [IDX_W-1:0]              last_idx,
	output logic                          up
);

	logic [bfi_pkg::CFG_W-1:0] table_length_q;
	logic                      ascending_q;
	logic [IDX_W:0]            len;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= bfi_pkg::TABLE_LENGTH_RST;
			ascending_q    <= bfi_pkg::ASCENDING_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bfi_pkg::REG_TABLE_LENGTH: table_length_q <= cfg_data;
				bfi_pkg::REG_ASCENDING:    ascending_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the used length to one through DEPTH
	always_comb begin
		if (int'(table_length_q) > DEPTH) begin
			len = (IDX_W+1)'(DEPTH);
		end else if (table_length_q == '0) begin
			len = (IDX_W+1)'(1);
		end else begin
			len = (IDX_W+1)'(table_length_q);
		end
	end

	assign last_idx = IDX_W'(len - (IDX_W+1)'(1));
	assign up       = ascending_q;

	// Accept a transaction whenever the queue has room
	assign busy            = q_status.full;
	assign push            = start && !q_status.full;
	assign push_item.op    = opcode;
	assign push_item.slot  = entry_index;
	assign push_item.data  = (opcode == bfi_pkg::OP_QUERY) ? query_value : breakpoint_value;

endmodule

// ----- design/bfi_div.sv -----
// Restoring divider for the segment fraction, one quotient bit per cycle.
module bfi_div #(
	parameter int FRAC_BITS = bfi_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfi_pkg::VALUE_W-1:0] num,
	input  logic [bfi_pkg::VALUE_W-1:0] den,
	output logic                        done,
	output logic [FRAC_BITS:0]          quot
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic                          run_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [bfi_pkg::VALUE_W:0]     rem_q;
	logic [bfi_pkg::VALUE_W-1:0]   den_q;
	logic [FRAC_BITS:0]            quot_q;
	logic                          ge;
	logic [bfi_pkg::VALUE_W:0]     rem_next;

	// Trial subtract for this bit
	assign ge       = rem_q >= {1'b0, den_q};
	assign rem_next = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_BITS);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= {rem_next[bfi_pkg::VALUE_W-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- design/bfi_back.sv -----
// Back end: breakpoint memory, clamp checks, segment scan, divider and result register.
module bfi_back #(
	parameter int DEPTH     = bfi_pkg::DEF_DEPTH,
	parameter int FRAC_BITS = bfi_pkg::DEF_FRAC_BITS,
	localparam int IDX_W    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfi_pkg::bfi_item_t           head,
	input  bfi_pkg::bfi_q_status_t       q_status,
	output logic                         pop,
	input  logic [IDX_W-1:0]             last_idx,
	input  logic                         up,
	output logic                         done,
	output logic [bfi_pkg::OUT_W-1:0]    fractional_index,
	output logic                         found
);

	localparam int SUM_W = (IDX_W + FRAC_BITS + 1 > bfi_pkg::OUT_W) ?
		(IDX_W + FRAC_BITS + 1) : bfi_pkg::OUT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;

	logic [2:0]                      state_q;
	logic [2:0]                      state_d;
	logic [bfi_pkg::VALUE_W-1:0]     mem [DEPTH];
	logic [bfi_pkg::VALUE_W-1:0]     rdata_q;
	logic [IDX_W-1:0]                raddr;
	logic                            we;
	logic signed [bfi_pkg::VALUE_W-1:0] q_q;
	logic signed [bfi_pkg::VALUE_W-1:0] prev_q;
	logic [IDX_W-1:0]                seg_q;
	logic signed [bfi_pkg::VALUE_W:0] q_x;
	logic signed [bfi_pkg::VALUE_W:0] lo_x;
	logic signed [bfi_pkg::VALUE_W:0] hi_x;
	logic signed [bfi_pkg::VALUE_W:0] num_x;
	logic signed [bfi_pkg::VALUE_W:0] den_x;
	logic                            hit;
	logic                            clamp_first;
	logic                            clamp_last;
	logic                            scan_end;
	logic [IDX_W:0]                  next_addr;
	logic                            div_start;
	logic                            div_done;
	logic [FRAC_BITS:0]              div_quot;
	logic                            emit;
	logic                            emit_found;
	logic [IDX_W-1:0]                res_seg;
	logic [FRAC_BITS:0]              res_quot;
	logic [SUM_W-1:0]                sum;
	logic                            done_q;
	logic                            found_q;
	logic [bfi_pkg::OUT_W-1:0]       frac_idx_q;

	// Breakpoint memory with registered read
	assign we = pop && (head.op == bfi_pkg::OP_WRITE) && (int'(head.slot) < DEPTH);

	always_ff @(posedge clk) begin
		if (we) mem[IDX_W'(head.slot)] <= head.data;
		rdata_q <= mem[raddr];
	end

	// Compare the query against the entries just read
	assign q_x  = {q_q[bfi_pkg::VALUE_W-1], q_q};
	assign lo_x = {prev_q[bfi_pkg::VALUE_W-1], prev_q};
	assign hi_x = {rdata_q[bfi_pkg::VALUE_W-1], rdata_q};

	assign clamp_first = up ? (q_q <= $signed(rdata_q)) : (q_q >= $signed(rdata_q));
	assign clamp_last  = up ? (q_q >= $signed(rdata_q)) : (q_q <= $signed(rdata_q));
	assign hit = up ? ((q_x >= lo_x) && (q_x < hi_x)) : ((q_x <= lo_x) && (q_x > hi_x));
	assign num_x = q_x - (up ? lo_x : hi_x);
	assign den_x = (up ? hi_x : lo_x) - (up ? lo_x : hi_x);

	assign next_addr = (IDX_W+1)'(seg_q) + (IDX_W+1)'(2);
	assign scan_end  = ((IDX_W+1)'(seg_q) + (IDX_W+1)'(1)) == (IDX_W+1)'(last_idx);

	// Sequence one command
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		raddr      = '0;
		div_start  = 1'b0;
		emit       = 1'b0;
		emit_found = 1'b1;
		res_seg    = '0;
		res_quot   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					if (head.op == bfi_pkg::OP_QUERY) state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (clamp_first) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					raddr   = last_idx;
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (!clamp_last) begin
					raddr   = IDX_W'(1);
					state_d = ST_SCAN;
				end else begin
					emit    = 1'b1;
					res_seg = last_idx;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (scan_end) begin
					emit       = 1'b1;
					emit_found = 1'b0;
					state_d    = ST_IDLE;
				end else begin
					raddr = next_addr[IDX_W-1:0];
				end
			end
			ST_DIV: begin
				if (div_done) begin
					emit     = 1'b1;
					res_seg  = seg_q;
					res_quot = div_quot;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state and the control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	// Hold query, previous entry and segment number
	always_ff @(posedge clk) begin
		if (pop) q_q <= $signed(head.data);
		if (state_q == ST_FIRST) prev_q <= $signed(rdata_q);
		if (state_q == ST_LAST) seg_q <= '0;
		if ((state_q == ST_SCAN) && !hit && !scan_end) begin
			prev_q <= $signed(rdata_q);
			seg_q  <= seg_q + 1'b1;
		end
	end

	bfi_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_x[bfi_pkg::VALUE_W-1:0]),
		.den   (den_x[bfi_pkg::VALUE_W-1:0]),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Form segment plus fraction, masked to the output width
	assign sum = (SUM_W'(res_seg) << FRAC_BITS) + SUM_W'(res_quot);

	always_ff @(posedge clk) begin
		if (emit) begin
			frac_idx_q <= emit_found ? sum[bfi_pkg::OUT_W-1:0] : '0;
			found_q    <= emit_found;
		end
	end

	assign done             = done_q;
	assign fractional_index = frac_idx_q;
	assign found            = found_q;

	// A result follows only a clamp, a scan or a finished division
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_FIRST || $past(state_q) == ST_LAST ||
			$past(state_q) == ST_SCAN || $past(state_q) == ST_DIV))
		else $error("result strobe without a finishing state");

	// A miss always reports a zero index
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (frac_idx_q == '0))
		else $error("miss with nonzero index");

	// The divider finishes only while the back end waits on it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// The scan never walks past the last used segment
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (seg_q < last_idx))
		else $error("scan index beyond the last segment");

endmodule
